// ----- rtl/spl_pkg.sv -----
// ----------------------------------------------------------------------------
// spl_pkg: shared types and constants
// Types for the light table's items, configuration and the control interface
// between sequencer and datapath.
// ----------------------------------------------------------------------------
package spl_pkg;

  // command codes
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_EMIT  = 2'd2;

  // register indexes (byte address is four times the index)
  localparam logic [1:0] REG_REF_X      = 2'd0;
  localparam logic [1:0] REG_REF_Y      = 2'd1;
  localparam logic [1:0] REG_REF_Z      = 2'd2;
  localparam logic [1:0] REG_BRIGHTNESS = 2'd3;

  localparam int ADDR_W = 4;

  localparam logic [8:0] BRIGHT_RESET = 9'd256;

  // distance thresholds and scale factors
  localparam int DIST_LIMIT  = 320;
  localparam int DIST_FULL   = 192;
  localparam int DIR_SCALE   = 120;
  localparam int ATTEN_SHIFT = 7;
  localparam int COL_SHIFT   = 8;

  // restoring division: seven quotient bits, one per cycle
  localparam int DIV_STEPS = 7;
  localparam int CNT_W     = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SUM,
    ST_EFF,
    ST_DIV,
    ST_WRITE,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [14:0]        light_strength;
    logic [7:0]         col_red;
    logic [7:0]         col_green;
    logic [7:0]         col_blue;
  } in_item_t;

  typedef struct packed {
    logic               entry_valid;
    logic [2:0]         list_position;
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic signed [7:0]  dir_x;
    logic signed [7:0]  dir_y;
    logic signed [7:0]  dir_z;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] ref_x;
    logic signed [15:0] ref_y;
    logic signed [15:0] ref_z;
    logic [8:0]         brightness;
  } cfg_t;

  // sequencer to datapath
  typedef struct packed {
    logic capture;
    logic clear_slots;
    logic calc_diff;
    logic calc_sum;
    logic calc_eff;
    logic div_step;
    logic write_slot;
    logic cnt_clr;
    logic cnt_inc;
    logic out_load;
    logic out_load_empty;
  } ctrl_cmd_t;

  // datapath to sequencer
  typedef struct packed {
    logic [1:0] in_cmd;
    logic       table_empty;
    logic       div_done;
    logic       slot_used;
    logic       slot_last;
    logic       out_free;
  } ctrl_status_t;

endpackage

// ----- rtl/spl_regs.sv -----
// ----------------------------------------------------------------------------
// spl_regs: configuration register bank
// APB-style slave holding the reference point and the emit brightness.
// ----------------------------------------------------------------------------
module spl_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spl_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output spl_pkg::cfg_t               cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_x      <= '0;
      cfg.ref_y      <= '0;
      cfg.ref_z      <= '0;
      cfg.brightness <= spl_pkg::BRIGHT_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        spl_pkg::REG_REF_X:      cfg.ref_x      <= pwdata[15:0];
        spl_pkg::REG_REF_Y:      cfg.ref_y      <= pwdata[15:0];
        spl_pkg::REG_REF_Z:      cfg.ref_z      <= pwdata[15:0];
        spl_pkg::REG_BRIGHTNESS: cfg.brightness <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[3:2])
      spl_pkg::REG_REF_X:      prdata = {16'b0, cfg.ref_x};
      spl_pkg::REG_REF_Y:      prdata = {16'b0, cfg.ref_y};
      spl_pkg::REG_REF_Z:      prdata = {16'b0, cfg.ref_z};
      spl_pkg::REG_BRIGHTNESS: prdata = {23'b0, cfg.brightness};
      default:                 prdata = '0;
    endcase
  end

endmodule

// ----- rtl/spl_dp.sv -----
// ----------------------------------------------------------------------------
// spl_dp: light table datapath
// Distance and attenuation, three bit-serial direction dividers, weakest slot
// scan, the slot table and the registered output stage.
// ----------------------------------------------------------------------------
module spl_dp #(
  parameter int SLOT_COUNT = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  spl_pkg::cfg_t         cfg,
  input  spl_pkg::in_item_t     in_item,
  input  spl_pkg::ctrl_cmd_t    cmd,
  output spl_pkg::ctrl_status_t status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output spl_pkg::out_item_t    out_item
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // captured item
  spl_pkg::in_item_t item;

  // distance stage
  logic [15:0] adx, ady, adz;
  logic        neg_x, neg_y, neg_z;
  logic [17:0] mdist;
  logic        in_range;
  logic [14:0] eff;

  // dividers and scan
  logic [15:0]    rem_x, rem_y, rem_z;
  logic [14:0]    dshift;
  logic [6:0]     q_x, q_y, q_z;
  logic [14:0]    low;
  logic [IW-1:0]  pick;
  logic [spl_pkg::CNT_W-1:0] cnt;
  logic [2:0]     pos_cnt;

  // slot table
  logic [14:0]       slot_strength [SLOT_COUNT];
  logic [14:0]       slot_red      [SLOT_COUNT];
  logic [14:0]       slot_green    [SLOT_COUNT];
  logic [14:0]       slot_blue     [SLOT_COUNT];
  logic signed [7:0] slot_dir_x    [SLOT_COUNT];
  logic signed [7:0] slot_dir_y    [SLOT_COUNT];
  logic signed [7:0] slot_dir_z    [SLOT_COUNT];

  // combinational helpers
  logic signed [16:0] dx, dy, dz;
  logic [16:0]        ndx, ndy, ndz;
  logic [8:0]         atten;
  logic [21:0]        atten_prod;
  logic [14:0]        eff_next;
  logic [15:0]        num_x, num_y, num_z;
  logic [22:0]        prod_r, prod_g, prod_b;
  logic [IW-1:0]      idx;
  logic               scan_on;
  logic [SLOT_COUNT-1:0] used;
  logic [SLOT_COUNT-1:0] above;
  logic [23:0]        br_r, br_g, br_b;
  logic               do_write;

  function automatic logic signed [7:0] sign_dir(input logic neg, input logic [6:0] q);
    logic [7:0] mag;
    mag = {1'b0, q};
    return neg ? 8'(-mag) : mag;
  endfunction

  function automatic logic [7:0] sat8(input logic [23:0] v);
    return (|v[23:16]) ? 8'hff : v[15:8];
  endfunction

  assign idx     = cnt[IW-1:0];
  assign scan_on = cnt < spl_pkg::CNT_W'(SLOT_COUNT);

  // offsets from the reference point
  assign dx  = {item.pos_x[15], item.pos_x} - {cfg.ref_x[15], cfg.ref_x};
  assign dy  = {item.pos_y[15], item.pos_y} - {cfg.ref_y[15], cfg.ref_y};
  assign dz  = {item.pos_z[15], item.pos_z} - {cfg.ref_z[15], cfg.ref_z};
  assign ndx = -dx;
  assign ndy = -dy;
  assign ndz = -dz;

  // attenuation beyond the full-strength radius
  assign atten      = 9'(spl_pkg::DIST_LIMIT) - mdist[8:0];
  assign atten_prod = 22'(item.light_strength) * 22'(atten[6:0]);
  assign eff_next   = (mdist <= 18'(spl_pkg::DIST_FULL)) ? item.light_strength
                    : atten_prod[21:spl_pkg::ATTEN_SHIFT];

  // dividend for each direction component
  assign num_x = 16'(adx[8:0]) * 16'(spl_pkg::DIR_SCALE);
  assign num_y = 16'(ady[8:0]) * 16'(spl_pkg::DIR_SCALE);
  assign num_z = 16'(adz[8:0]) * 16'(spl_pkg::DIR_SCALE);

  // stored colour
  assign prod_r = 23'(item.col_red)   * 23'(eff);
  assign prod_g = 23'(item.col_green) * 23'(eff);
  assign prod_b = 23'(item.col_blue)  * 23'(eff);

  assign do_write = cmd.write_slot && in_range && (low < eff);

  // used slots and the slots after the current one
  always_comb begin
    for (int j = 0; j < SLOT_COUNT; j++) begin
      used[j]  = slot_strength[j] != '0;
      above[j] = spl_pkg::CNT_W'(j) > cnt;
    end
  end

  // emitted colour
  assign br_r = 24'(slot_red[idx])   * 24'(cfg.brightness);
  assign br_g = 24'(slot_green[idx]) * 24'(cfg.brightness);
  assign br_b = 24'(slot_blue[idx])  * 24'(cfg.brightness);

  // status to the sequencer
  assign status.in_cmd      = in_item.cmd;
  assign status.table_empty = ~|used;
  assign status.div_done    = cnt == spl_pkg::CNT_W'(spl_pkg::DIV_STEPS - 1);
  assign status.slot_used   = used[idx];
  assign status.slot_last   = ~|(used & above);
  assign status.out_free    = !out_valid || !out_stall;

  // item capture, distance and attenuation
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_item;
    end
    if (cmd.calc_diff) begin
      neg_x <= dx[16];
      neg_y <= dy[16];
      neg_z <= dz[16];
      adx   <= dx[16] ? ndx[15:0] : dx[15:0];
      ady   <= dy[16] ? ndy[15:0] : dy[15:0];
      adz   <= dz[16] ? ndz[15:0] : dz[15:0];
    end
    if (cmd.calc_sum) begin
      mdist    <= 18'(adx) + 18'(ady) + 18'(adz);
      in_range <= (18'(adx) + 18'(ady) + 18'(adz) != '0)
               && (18'(adx) + 18'(ady) + 18'(adz) < 18'(spl_pkg::DIST_LIMIT));
    end
    if (cmd.calc_eff) begin
      eff <= eff_next;
    end
  end

  // dividers and weakest slot scan
  always_ff @(posedge clk) begin
    if (cmd.calc_eff) begin
      rem_x  <= num_x;
      rem_y  <= num_y;
      rem_z  <= num_z;
      dshift <= {mdist[8:0], 6'b0};
      q_x    <= '0;
      q_y    <= '0;
      q_z    <= '0;
      low    <= '1;
      pick   <= '0;
    end else if (cmd.div_step) begin
      if (rem_x >= 16'(dshift)) begin
        rem_x <= rem_x - 16'(dshift);
        q_x   <= {q_x[5:0], 1'b1};
      end else begin
        q_x   <= {q_x[5:0], 1'b0};
      end
      if (rem_y >= 16'(dshift)) begin
        rem_y <= rem_y - 16'(dshift);
        q_y   <= {q_y[5:0], 1'b1};
      end else begin
        q_y   <= {q_y[5:0], 1'b0};
      end
      if (rem_z >= 16'(dshift)) begin
        rem_z <= rem_z - 16'(dshift);
        q_z   <= {q_z[5:0], 1'b1};
      end else begin
        q_z   <= {q_z[5:0], 1'b0};
      end
      dshift <= dshift >> 1;
      if (scan_on && (slot_strength[idx] < low)) begin
        low  <= slot_strength[idx];
        pick <= idx;
      end
    end
  end

  // step counter and list position
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      pos_cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt     <= '0;
      pos_cnt <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.out_load) begin
        pos_cnt <= pos_cnt + 1'b1;
      end
    end
  end

  // slot strengths, cleared by reset and by the clear command
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_slots) begin
      for (int j = 0; j < SLOT_COUNT; j++) begin
        slot_strength[j] <= '0;
      end
    end else if (do_write) begin
      slot_strength[pick] <= eff;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (do_write) begin
      slot_red[pick]   <= prod_r[22:spl_pkg::COL_SHIFT];
      slot_green[pick] <= prod_g[22:spl_pkg::COL_SHIFT];
      slot_blue[pick]  <= prod_b[22:spl_pkg::COL_SHIFT];
      slot_dir_x[pick] <= sign_dir(neg_x, q_x);
      slot_dir_y[pick] <= sign_dir(neg_y, q_y);
      slot_dir_z[pick] <= sign_dir(neg_z, q_z);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load || cmd.out_load_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.entry_valid   <= 1'b1;
      out_item.list_position <= pos_cnt + 1'b1;
      out_item.out_red       <= sat8(br_r);
      out_item.out_green     <= sat8(br_g);
      out_item.out_blue      <= sat8(br_b);
      out_item.dir_x         <= slot_dir_x[idx];
      out_item.dir_y         <= slot_dir_y[idx];
      out_item.dir_z         <= slot_dir_z[idx];
      out_item.last          <= status.slot_last;
    end else if (cmd.out_load_empty) begin
      out_item <= '{last: 1'b1, default: '0};
    end
  end

`ifndef SYNTHESIS
  a_dir_bound: assert property (@(posedge clk) disable iff (rst)
    do_write |-> (q_x <= 7'(spl_pkg::DIR_SCALE)) && (q_y <= 7'(spl_pkg::DIR_SCALE))
                 && (q_z <= 7'(spl_pkg::DIR_SCALE)))
    else $error("direction quotient above scale");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load || cmd.out_load_empty) |-> status.out_free)
    else $error("output register overwritten before taken");
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_slots |=> status.table_empty)
    else $error("table not empty after clear");
`endif

endmodule

// ----- rtl/spl_ctrl.sv -----
// ----------------------------------------------------------------------------
// spl_ctrl: light table sequencer
// Steps an add through distance, attenuation and division, clears the table on a
// clear, and walks the table on an emit.
// ----------------------------------------------------------------------------
module spl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  spl_pkg::ctrl_status_t status,
  output spl_pkg::ctrl_cmd_t    cmd
);

  spl_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      spl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (status.in_cmd)
            spl_pkg::CMD_ADD: begin
              state_next = spl_pkg::ST_DIFF;
            end
            spl_pkg::CMD_CLEAR: begin
              cmd.clear_slots = 1'b1;
            end
            spl_pkg::CMD_EMIT: begin
              cmd.cnt_clr = 1'b1;
              state_next  = status.table_empty ? spl_pkg::ST_EMPTY : spl_pkg::ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      spl_pkg::ST_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_next    = spl_pkg::ST_SUM;
      end
      spl_pkg::ST_SUM: begin
        cmd.calc_sum = 1'b1;
        state_next   = spl_pkg::ST_EFF;
      end
      spl_pkg::ST_EFF: begin
        cmd.calc_eff = 1'b1;
        cmd.cnt_clr  = 1'b1;
        state_next   = spl_pkg::ST_DIV;
      end
      spl_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (status.div_done) begin
          state_next = spl_pkg::ST_WRITE;
        end
      end
      spl_pkg::ST_WRITE: begin
        cmd.write_slot = 1'b1;
        state_next     = spl_pkg::ST_IDLE;
      end
      spl_pkg::ST_EMIT: begin
        if (!status.slot_used) begin
          cmd.cnt_inc = 1'b1;
        end else if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.cnt_inc  = 1'b1;
          if (status.slot_last) begin
            state_next = spl_pkg::ST_IDLE;
          end
        end
      end
      spl_pkg::ST_EMPTY: begin
        if (status.out_free) begin
          cmd.out_load_empty = 1'b1;
          state_next         = spl_pkg::ST_IDLE;
        end
      end
      default: state_next = spl_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == spl_pkg::ST_EMIT) |-> !status.table_empty)
    else $error("emit walk over an empty table");
  a_empty_once: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load_empty |=> (state == spl_pkg::ST_IDLE))
    else $error("empty result not followed by idle");
  a_write_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == spl_pkg::ST_WRITE) |-> ($past(state) == spl_pkg::ST_DIV) && $past(status.div_done))
    else $error("slot write without finished division");
`endif

endmodule

// ----- rtl/strongest_point_light_table.sv -----
// Add: offset, sum, attenuation, seven divider steps that also scan the slots,
//   slot write and idle until the next acceptance; no result. Clear: no result.
// Emit: one slot per cycle up to the last used one, a used slot waiting until the
//   output register is free; each result registered as it is formed and held while
//   out_stall is high. Empty table: one result. The sequencer works on one item
// at a time. Synchronous active-high reset empties the table, refs 0, brightness 256.
// ----------------------------------------------------------------------------
// strongest_point_light_table: top level
// Keeps the strongest point lights near a reference point and lists them.
// ----------------------------------------------------------------------------
module strongest_point_light_table #(
  parameter int SLOT_COUNT = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spl_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  spl_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output spl_pkg::out_item_t          out_item
);

  spl_pkg::cfg_t         cfg;
  spl_pkg::ctrl_cmd_t    cmd;
  spl_pkg::ctrl_status_t status;

  // configuration registers
  spl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  spl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  spl_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
